@@ design/stbs_pkg.sv @@
// Shared field widths, request codes and control structures for the sorted table bound search.
package stbs_pkg;

   // Widths of the word fields on the request and response channels.
   localparam int TYPE_W  = 2;
   localparam int INDEX_W = 10;
   localparam int DATA_W  = 32;
   localparam int RANGE_W = 11;

   // Request codes carried in req_type.
   localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOWER = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_UPPER = 2'd2;

   // Commands from the front end to the search sequencer.
   typedef struct packed {
      logic start;
      logic upper;
      logic ack;
   } ctrl_type;

   // Status from the search sequencer back to the front end.
   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

@@ design/stbs_if.sv @@
// Valid/ready channel interfaces for request and response words.

interface stbs_req_if;
   logic                             valid;
   logic                             ready;
   logic [stbs_pkg::TYPE_W-1:0]      req_type;
   logic [stbs_pkg::INDEX_W-1:0]     entry_index;
   logic signed [stbs_pkg::DATA_W-1:0] entry_or_key;
   logic [stbs_pkg::RANGE_W-1:0]     range_start;
   logic [stbs_pkg::RANGE_W-1:0]     range_end;

   modport source (output valid, output req_type, output entry_index, output entry_or_key,
                   output range_start, output range_end, input ready);
   modport sink   (input valid, input req_type, input entry_index, input entry_or_key,
                   input range_start, input range_end, output ready);
endinterface

interface stbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [stbs_pkg::RANGE_W-1:0] found_position;

   modport source (output valid, output found_position, input ready);
   modport sink   (input valid, input found_position, output ready);
endinterface

@@ design/stbs_table.sv @@
// Table memory with one write port and two registered read ports.
module stbs_table #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
   input  logic signed [stbs_pkg::DATA_W-1:0] wr_data,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr_a,
   input  logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr_b,
   output logic signed [stbs_pkg::DATA_W-1:0] rd_data_a,
   output logic signed [stbs_pkg::DATA_W-1:0] rd_data_b
);

   logic signed [stbs_pkg::DATA_W-1:0] table_mem [TABLE_DEPTH];
   logic signed [stbs_pkg::DATA_W-1:0] rd_data_a_ff;
   logic signed [stbs_pkg::DATA_W-1:0] rd_data_b_ff;

   // Write on request; both read ports are registered every cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= table_mem[rd_addr_a];
      rd_data_b_ff <= table_mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ design/stbs_search.sv @@
// Binary search sequencer: one halving step per cycle with both next midpoints prefetched.
module stbs_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  stbs_pkg::ctrl_type                      ctrl,
   input  logic signed [stbs_pkg::DATA_W-1:0]      key,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]        lo_start,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]        hi_start,
   output logic [$clog2(TABLE_DEPTH)-1:0]          rd_addr_a,
   output logic [$clog2(TABLE_DEPTH)-1:0]          rd_addr_b,
   input  logic signed [stbs_pkg::DATA_W-1:0]      rd_data_a,
   input  logic signed [stbs_pkg::DATA_W-1:0]      rd_data_b,
   output stbs_pkg::status_type                    status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]        pos
);

   localparam int POS_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_STEP   = 3'b010,
      S_RESULT = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [POS_W-1:0]                   lo_ff, lo_in;
   logic [POS_W-1:0]                   hi_ff, hi_in;
   logic signed [stbs_pkg::DATA_W-1:0] key_ff, key_in;
   logic                               upper_ff, upper_in;
   logic                               sel_ff, sel_in;

   logic [POS_W-1:0]                   mid;
   logic [POS_W-1:0]                   mid_left;
   logic [POS_W-1:0]                   mid_right;
   logic [POS_W-1:0]                   mid_start;
   logic signed [stbs_pkg::DATA_W-1:0] entry;
   logic                               go_right;

   // Midpoint of the current range, of both ranges that the next step can leave, and of the start range.
   always_comb begin
      mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
      mid_left  = lo_ff + ((mid - lo_ff) >> 1);
      mid_right = mid + POS_W'(1) + ((hi_ff - mid - POS_W'(1)) >> 1);
      mid_start = lo_start + ((hi_start - lo_start) >> 1);
   end

   // Shared compare: the entry at the midpoint comes from whichever port was aimed at it.
   always_comb begin
      entry    = sel_ff ? rd_data_b : rd_data_a;
      go_right = upper_ff ? (entry <= key_ff) : (entry < key_ff);
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      key_in    = key_ff;
      upper_in  = upper_ff;
      sel_in    = sel_ff;
      rd_addr_a = ADDR_W'(mid_left);
      rd_addr_b = ADDR_W'(mid_right);
      unique case (state_ff)
         S_IDLE: begin
            rd_addr_a = ADDR_W'(mid_start);
            if (ctrl.start) begin
               lo_in    = lo_start;
               hi_in    = hi_start;
               key_in   = key;
               upper_in = ctrl.upper;
               sel_in   = 1'b0;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (lo_ff >= hi_ff) begin
               state_in = S_RESULT;
            end else begin
               sel_in = go_right;
               if (go_right) begin
                  lo_in = mid + POS_W'(1);
               end else begin
                  hi_in = mid;
               end
            end
         end
         S_RESULT: begin
            if (ctrl.ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      key_ff   <= key_in;
      upper_ff <= upper_in;
      sel_ff   <= sel_in;
   end

   assign status.idle = (state_ff == S_IDLE);
   assign status.done = (state_ff == S_RESULT);
   assign pos         = lo_ff;

endmodule

@@ design/sorted_table_bound_search.sv @@
// A write word does not occupy the search unit, which stays ready for the next request.
// A query runs one halving step per cycle of the shared compare unit fed by two prefetching
// table ports, and its result waits until the response output register is free.
// The search unit turns idle and takes the next request once the response word is loaded.
// Synchronous reset clears the sequencer and the response valid; table contents are undefined.
module sorted_table_bound_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   stbs_req_if.sink   req_if,
   stbs_rsp_if.source rsp_if
);

   localparam int POS_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   stbs_pkg::ctrl_type                 ctrl;
   stbs_pkg::status_type               status;
   logic                               req_accept;
   logic                               is_query;
   logic                               wr_en;
   logic [POS_W-1:0]                   lo_clamp;
   logic [POS_W-1:0]                   hi_clamp;
   logic [ADDR_W-1:0]                  rd_addr_a;
   logic [ADDR_W-1:0]                  rd_addr_b;
   logic signed [stbs_pkg::DATA_W-1:0] rd_data_a;
   logic signed [stbs_pkg::DATA_W-1:0] rd_data_b;
   logic [POS_W-1:0]                   pos;
   logic [31:0]                        pos_wide;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [stbs_pkg::RANGE_W-1:0]       rsp_pos_ff, rsp_pos_in;

   // Request decode; the search unit takes a new word only when it is idle.
   assign req_if.ready = status.idle;
   assign req_accept   = req_if.valid && req_if.ready;
   assign is_query     = (req_if.req_type == stbs_pkg::REQ_LOWER) ||
                         (req_if.req_type == stbs_pkg::REQ_UPPER);
   assign wr_en        = req_accept && (req_if.req_type == stbs_pkg::REQ_WRITE) &&
                         (32'(req_if.entry_index) < TABLE_DEPTH);

   // Range bounds beyond the table are saturated to its depth.
   always_comb begin
      lo_clamp = (32'(req_if.range_start) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH)
                                                          : POS_W'(req_if.range_start);
      hi_clamp = (32'(req_if.range_end) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH)
                                                        : POS_W'(req_if.range_end);
   end

   // Commands to the sequencer; a finished result is taken once the output register is free.
   always_comb begin
      ctrl.start = req_accept && is_query;
      ctrl.upper = (req_if.req_type == stbs_pkg::REQ_UPPER);
      ctrl.ack   = status.done && (!rsp_valid_ff || rsp_if.ready);
   end

   stbs_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (ADDR_W'(req_if.entry_index)),
      .wr_data   (req_if.entry_or_key),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   stbs_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .key       (req_if.entry_or_key),
      .lo_start  (lo_clamp),
      .hi_start  (hi_clamp),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .status    (status),
      .pos       (pos)
   );

   // Response output register.
   assign pos_wide = 32'(pos);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (ctrl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_wide[stbs_pkg::RANGE_W-1:0];
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pos_ff <= rsp_pos_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.found_position = rsp_pos_ff;

endmodule

@@ design/stbs_checker.sv @@
// Port-level checker for the sorted table bound search, bound to the top level.
module stbs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [stbs_pkg::TYPE_W-1:0]    req_type,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [stbs_pkg::RANGE_W-1:0]   found_position
);

   logic req_accept;
   logic query_accept;
   logic write_accept;

   assign req_accept   = req_valid && req_ready;
   assign query_accept = req_accept && ((req_type == stbs_pkg::REQ_LOWER) ||
                                        (req_type == stbs_pkg::REQ_UPPER));
   assign write_accept = req_accept && (req_type == stbs_pkg::REQ_WRITE);

   // A query occupies the search unit, so no request is taken in the following cycle.
   query_busy_a: assert property (@(posedge clock) disable iff (reset)
      query_accept |=> !req_ready)
      else $error("request taken right after a query was accepted");

   // A write does not occupy the search unit.
   write_free_a: assert property (@(posedge clock) disable iff (reset)
      write_accept |=> req_ready)
      else $error("block not ready after a write");

   // A stalled response word stays valid.
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // A stalled response word keeps its value.
   rsp_stable_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(found_position))
      else $error("response word changed while stalled");

endmodule

bind sorted_table_bound_search stbs_checker u_stbs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_type       (req_if.req_type),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .found_position (rsp_if.found_position)
);

@@ bench/sorted_table_bound_search_tb.sv @@
// Self-checking bench for the sorted table bound search: directed table, then random runs.
module sorted_table_bound_search_tb;

   localparam int TYPE_W  = stbs_pkg::TYPE_W;
   localparam int INDEX_W = stbs_pkg::INDEX_W;
   localparam int DATA_W  = stbs_pkg::DATA_W;
   localparam int RANGE_W = stbs_pkg::RANGE_W;

   localparam int DEPTH = 1024;
   localparam int ITEMS = 1100;
   localparam int LIMIT_CYCLES = 200000;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

   // One request word, with an optional hand-written expected position.
   typedef struct packed {
      logic [TYPE_W-1:0]         op;
      logic [INDEX_W-1:0]        index;
      logic signed [DATA_W-1:0]  word;
      logic [RANGE_W-1:0]        first;
      logic [RANGE_W-1:0]        last;
      bit                        typed;
      logic [RANGE_W-1:0]        pos;
   } table_op_type;

   logic clock = 1'b0;
   logic reset;

   stbs_req_if req_if ();
   stbs_rsp_if rsp_if ();

   sorted_table_bound_search #(.TABLE_DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #10 clock = ~clock;

   // Shadow copy of the table and of which entries have been written.
   logic signed [DATA_W-1:0] shadow_table [DEPTH];
   bit                       shadow_written [DEPTH];
   logic [RANGE_W-1:0]       positions_due [$];

   bit calm = 1'b0;
   int sent = 0;
   int writes = 0;
   int lowers = 0;
   int uppers = 0;
   int unsorted_runs = 0;
   int checked = 0;
   int failures = 0;

   // Directed words: extremes of the fields and the special cases.
   table_op_type directed [25] = '{
      // Empty and inverted ranges answer the start without touching the table.
      '{stbs_pkg::REQ_LOWER, 10'd0, 32'sd0, 11'd5, 11'd5, 1'b1, 11'd5},
      '{stbs_pkg::REQ_UPPER, 10'd0, -32'sd1, 11'd900, 11'd3, 1'b1, 11'd900},
      // Bounds beyond the table saturate to its depth.
      '{stbs_pkg::REQ_LOWER, 10'd0, WORD_MAX, 11'd2047, 11'd2047, 1'b1, 11'd1024},
      '{stbs_pkg::REQ_UPPER, 10'd0, WORD_MIN, 11'd1500, 11'd10, 1'b1, 11'd1024},
      // The unused request code is dropped.
      '{REQ_UNUSED, 10'h3ff, -32'sd1, 11'h7ff, 11'h7ff, 1'b0, 11'd0},
      // A sorted run at the bottom of the table, both extremes repeated.
      '{stbs_pkg::REQ_WRITE, 10'd0, WORD_MIN, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd1, WORD_MIN, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd2, -32'sd5, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd3, 32'sd0, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd4, 32'sd0, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd5, 32'sd7, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd6, WORD_MAX, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd7, WORD_MAX, 11'd0, 11'd0, 1'b0, 11'd0},
      // A short run at the top of the table.
      '{stbs_pkg::REQ_WRITE, 10'd1021, -32'sd1, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd1022, WORD_MAX, 11'd0, 11'd0, 1'b0, 11'd0},
      '{stbs_pkg::REQ_WRITE, 10'd1023, WORD_MAX, 11'd0, 11'd0, 1'b0, 11'd0},
      // Extreme keys, and a repeated zero key, over the bottom run.
      '{stbs_pkg::REQ_LOWER, 10'd0, WORD_MIN, 11'd0, 11'd8, 1'b1, 11'd0},
      '{stbs_pkg::REQ_UPPER, 10'd0, WORD_MIN, 11'd0, 11'd8, 1'b1, 11'd2},
      '{stbs_pkg::REQ_LOWER, 10'd0, WORD_MAX, 11'd0, 11'd8, 1'b1, 11'd6},
      '{stbs_pkg::REQ_UPPER, 10'd0, WORD_MAX, 11'd0, 11'd8, 1'b1, 11'd8},
      '{stbs_pkg::REQ_LOWER, 10'd0, 32'sd0, 11'd0, 11'd8, 1'b0, 11'd0},
      '{stbs_pkg::REQ_UPPER, 10'd0, 32'sd0, 11'd2, 11'd8, 1'b0, 11'd0},
      // Ends beyond or at the end of the table over the top run.
      '{stbs_pkg::REQ_LOWER, 10'd0, 32'sd5, 11'd1021, 11'd2047, 1'b0, 11'd0},
      '{stbs_pkg::REQ_UPPER, 10'd0, WORD_MAX, 11'd1021, 11'd1500, 1'b1, 11'd1024},
      '{stbs_pkg::REQ_LOWER, 10'd0, -32'sd1, 11'd1023, 11'd1024, 1'b0, 11'd0}
   };

   // Binary search over the shadow table; blind is set if an unwritten entry is read.
   function automatic logic [RANGE_W-1:0] bound_position(input bit upper,
         input logic signed [DATA_W-1:0] key, input logic [RANGE_W-1:0] first,
         input logic [RANGE_W-1:0] last, output bit blind);
      int lo;
      int hi;
      int mid;
      bit right;
      lo = (int'(first) > DEPTH) ? DEPTH : int'(first);
      hi = (int'(last) > DEPTH) ? DEPTH : int'(last);
      blind = 1'b0;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (!shadow_written[mid])
            blind = 1'b1;
         right = upper ? (shadow_table[mid] <= key) : (shadow_table[mid] < key);
         if (right)
            lo = mid + 1;
         else
            hi = mid;
      end
      return lo[RANGE_W-1:0];
   endfunction

   // A query that mostly targets the current run and never reads an unwritten entry.
   function automatic table_op_type make_query(input int base, input int span);
      table_op_type q;
      bit blind;
      int s;
      int e;
      int t;
      q = '0;
      q.op = $urandom_range(0, 1) ? stbs_pkg::REQ_UPPER : stbs_pkg::REQ_LOWER;
      q.index = INDEX_W'($urandom);
      for (int tries = 0; tries < 8; tries++) begin
         if ($urandom_range(0, 4) != 0) begin
            s = base + $urandom_range(0, span);
            e = base + $urandom_range(0, span);
            if (s > e && $urandom_range(0, 6) != 0) begin
               t = s;
               s = e;
               e = t;
            end
            if (base + span == DEPTH && $urandom_range(0, 3) == 0)
               e = $urandom_range(DEPTH, 2047);
            case ($urandom_range(0, 5)) inside
               [0:1]: q.word = shadow_table[base + $urandom_range(0, span - 1)];
               2: q.word = shadow_table[base + $urandom_range(0, span - 1)] + 1;
               3: q.word = shadow_table[base + $urandom_range(0, span - 1)] - 1;
               4: q.word = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
               default: q.word = $urandom;
            endcase
         end else begin
            s = $urandom_range(0, 2047);
            e = $urandom_range(0, 2047);
            q.word = $urandom_range(0, 3) == 0 ? WORD_MIN : $urandom;
         end
         q.first = RANGE_W'(s);
         q.last = RANGE_W'(e);
         void'(bound_position(q.op == stbs_pkg::REQ_UPPER, q.word, q.first, q.last, blind));
         if (!blind)
            return q;
      end
      // Fall back to an empty range, which reads nothing.
      q.first = RANGE_W'($urandom_range(int'(q.last), 2047));
      return q;
   endfunction

   // Offer one word, wait for the handshake and update the shadow state on acceptance.
   task automatic issue(input table_op_type w);
      logic [RANGE_W-1:0] pos;
      bit blind;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.req_type     <= w.op;
      req_if.entry_index  <= w.index;
      req_if.entry_or_key <= w.word;
      req_if.range_start  <= w.first;
      req_if.range_end    <= w.last;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      case (w.op) inside
         stbs_pkg::REQ_WRITE: begin
            shadow_table[w.index] = w.word;
            shadow_written[w.index] = 1'b1;
            writes++;
            sent++;
         end
         stbs_pkg::REQ_LOWER, stbs_pkg::REQ_UPPER: begin
            pos = bound_position(w.op == stbs_pkg::REQ_UPPER, w.word, w.first, w.last, blind);
            if (w.typed)
               pos = w.pos;
            positions_due = {positions_due, pos};
            if (w.op == stbs_pkg::REQ_UPPER)
               uppers++;
            else
               lowers++;
            sent++;
         end
         default: ;
      endcase
      calm = (sent >= ITEMS - 120);
      @(negedge clock);
   endtask

   // Stimulus: reset, the directed table, then random runs of writes and queries.
   initial begin
      table_op_type w;
      int base;
      int span;
      int queries;
      bit sorted_run;
      longint level;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.req_type = stbs_pkg::REQ_WRITE;
      req_if.entry_index = '0;
      req_if.entry_or_key = '0;
      req_if.range_start = '0;
      req_if.range_end = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i])
         issue(directed[i]);

      while (sent < ITEMS) begin
         // Pick a run: mostly short, now and then long, rarely longer, up to the whole table.
         case ($urandom_range(0, 19)) inside
            0: span = (sent < ITEMS / 2) ? $urandom_range(201, DEPTH) : $urandom_range(1, 32);
            [1:4]: span = $urandom_range(33, 200);
            default: span = $urandom_range(1, 32);
         endcase
         base = $urandom_range(0, DEPTH - span);
         sorted_run = ($urandom_range(0, 4) != 0);
         if (!sorted_run)
            unsorted_runs++;
         level = ($urandom_range(0, 5) == 0) ? longint'(WORD_MIN) : longint'(int'($urandom));

         // Fill the run in ascending index order.
         for (int i = 0; i < span; i++) begin
            w = '0;
            w.op = stbs_pkg::REQ_WRITE;
            w.index = INDEX_W'(base + i);
            w.first = RANGE_W'($urandom);
            w.last = RANGE_W'($urandom);
            if (sorted_run) begin
               w.word = level[DATA_W-1:0];
               case ($urandom_range(0, 3))
                  0: level += 0;
                  1: level += longint'($urandom_range(1, 3));
                  2: level += longint'($urandom_range(1, 1000));
                  default: level += longint'($urandom_range(0, 1 << 26));
               endcase
               if (level > longint'(WORD_MAX))
                  level = longint'(WORD_MAX);
            end else begin
               w.word = $urandom;
            end
            issue(w);
         end

         // Query the run, with an occasional stray write or dropped word.
         queries = $urandom_range(4, 20);
         for (int i = 0; i < queries; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               w = '0;
               w.op = stbs_pkg::REQ_WRITE;
               w.index = INDEX_W'($urandom);
               w.word = $urandom;
               issue(w);
            end else if ($urandom_range(0, 30) == 0) begin
               w = '0;
               w.op = REQ_UNUSED;
               w.index = INDEX_W'($urandom);
               w.word = $urandom;
               w.first = RANGE_W'($urandom);
               w.last = RANGE_W'($urandom);
               issue(w);
            end
            issue(make_query(base, span));
         end
      end
      req_if.valid <= 1'b0;

      // Drain the outstanding positions, then wait for stray words.
      while (positions_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Driven %0d writes, %0d lower-bound and %0d upper-bound queries.",
               writes, lowers, uppers);
      $display("Checked %0d positions; %0d unsorted runs searched.", checked, unsorted_runs);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Response side: ready stalls in bursts, none in the closing stretch.
   initial begin
      int stall;
      stall = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 6) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted response word with the oldest expected position.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (positions_due.size() == 0) begin
            $error("found_position: no word expected, actual %0d", rsp_if.found_position);
            failures++;
         end else begin
            if (rsp_if.found_position !== positions_due[0]) begin
               $error("found_position mismatch: expected %0d, actual %0d",
                      positions_due[0], rsp_if.found_position);
               failures++;
            end
            void'(positions_due.pop_front());
            checked++;
         end
      end
   end

   // Watchdog against a hung handshake.
   initial begin
      #(20 * LIMIT_CYCLES);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
